[rtl/core/sorted_key_table_search_insert_core_assert.svh]
// Assertion macros shared by the checker of the sorted key table core.
// Plain text macros only; no dependencies.
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_CORE_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted key table assertion failed");

// Consequent checked in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted key table assertion failed");

`endif

[rtl/core/skt_pkg.sv]
// Types and constants of the sorted key table core.
// No dependencies; used by the controller, the top level and the checker.
`timescale 1ns / 1ps

package skt_pkg;

	localparam int KEY_W     = 32;
	localparam int PAYLOAD_W = 64;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 10;
	localparam int TOTAL_W   = 11;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PROBE,
		S_COMPARE,
		S_TAIL_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_WRITE,
		S_DONE
	} state_t;

	// Strobes that the controller drives into both table memories.
	typedef struct packed {
		logic rd_en;
		logic we;
	} mem_ctl_t;

endpackage

[rtl/core/skt_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/skt_ctrl.sv]
// Sequencer and shared key comparator of the sorted key table core.
// Uses skt_pkg; drives the key and payload memories instantiated at the top level.
`timescale 1ns / 1ps

module skt_ctrl #(
	parameter int CAPACITY = 1024,
	parameter int AW = $clog2(CAPACITY),
	parameter int CW = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_cmd,
	input  logic [skt_pkg::KEY_W-1:0]     in_key,
	input  logic [skt_pkg::PAYLOAD_W-1:0] in_payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [skt_pkg::STATUS_W-1:0]  out_status,
	output logic [AW-1:0]                 out_pos,
	output logic [skt_pkg::PAYLOAD_W-1:0] out_payload,
	output logic [CW-1:0]                 out_total,
	output skt_pkg::mem_ctl_t             mem_ctl,
	output logic [AW-1:0]                 rd_addr,
	output logic [AW-1:0]                 wr_addr,
	output logic [skt_pkg::KEY_W-1:0]     wr_key,
	output logic [skt_pkg::PAYLOAD_W-1:0] wr_payload,
	input  logic [skt_pkg::KEY_W-1:0]     rd_key,
	input  logic [skt_pkg::PAYLOAD_W-1:0] rd_payload
);

	skt_pkg::state_t state_q, state_d;

	logic                          cmd_q, cmd_d;
	logic [skt_pkg::KEY_W-1:0]     key_q, key_d;
	logic [skt_pkg::PAYLOAD_W-1:0] pay_q, pay_d;
	logic [AW-1:0]                 lo_q, lo_d;
	logic [AW-1:0]                 hi_q, hi_d;
	logic [AW-1:0]                 idx_q, idx_d;
	logic                          last_q, last_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [skt_pkg::STATUS_W-1:0]  res_status_q, res_status_d;
	logic [AW-1:0]                 res_pos_q, res_pos_d;
	logic [skt_pkg::PAYLOAD_W-1:0] res_pay_q, res_pay_d;
	logic                          out_valid_q, out_valid_d;
	logic [skt_pkg::STATUS_W-1:0]  out_status_q, out_status_d;
	logic [AW-1:0]                 out_pos_q, out_pos_d;
	logic [skt_pkg::PAYLOAD_W-1:0] out_pay_q, out_pay_d;
	logic [CW-1:0]                 out_total_q, out_total_d;

	logic [AW:0]   span_sum;
	logic [AW-1:0] mid;
	logic [AW-1:0] count_last;
	logic          key_less;
	logic          key_equal;

	// Shared compare unit: the word just read against the key being handled.
	assign key_less  = rd_key < key_q;
	assign key_equal = rd_key == key_q;

	assign span_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = span_sum[AW:1];
	assign count_last = AW'(count_q - CW'(1));

	always_comb begin
		state_d      = state_q;
		cmd_d        = cmd_q;
		key_d        = key_q;
		pay_d        = pay_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		idx_d        = idx_q;
		last_d       = last_q;
		count_d      = count_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		res_pay_d    = res_pay_q;
		out_status_d = out_status_q;
		out_pos_d    = out_pos_q;
		out_pay_d    = out_pay_q;
		out_total_d  = out_total_q;
		out_valid_d  = out_valid_q && !out_ready;
		in_ready     = 1'b0;
		mem_ctl      = '0;
		rd_addr      = mid;
		wr_addr      = idx_q + AW'(1);
		wr_key       = rd_key;
		wr_payload   = rd_payload;

		case (state_q)
			skt_pkg::S_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = count_last;
				if (in_valid) begin
					cmd_d     = in_cmd;
					key_d     = in_key;
					pay_d     = in_payload;
					lo_d      = '0;
					hi_d      = count_last;
					res_pos_d = '0;
					res_pay_d = '0;
					if (in_cmd == skt_pkg::CMD_LOOKUP) begin
						if (count_q == '0) begin
							res_status_d = skt_pkg::STATUS_MISS;
							state_d      = skt_pkg::S_DONE;
						end else begin
							state_d = skt_pkg::S_PROBE;
						end
					end else if (count_q >= CW'(CAPACITY)) begin
						res_status_d = skt_pkg::STATUS_FULL;
						state_d      = skt_pkg::S_DONE;
					end else if (count_q == '0) begin
						state_d = skt_pkg::S_WRITE;
					end else begin
						// Fetch the last key to see whether the new entry simply appends.
						mem_ctl.rd_en = 1'b1;
						state_d       = skt_pkg::S_TAIL_CMP;
					end
				end
			end
			skt_pkg::S_TAIL_CMP: begin
				if (key_less) begin
					lo_d    = AW'(count_q);
					state_d = skt_pkg::S_WRITE;
				end else begin
					state_d = skt_pkg::S_PROBE;
				end
			end
			skt_pkg::S_PROBE: begin
				if (lo_q < hi_q) begin
					mem_ctl.rd_en = 1'b1;
					last_d        = 1'b0;
					state_d       = skt_pkg::S_COMPARE;
				end else if (cmd_q == skt_pkg::CMD_LOOKUP) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = lo_q;
					last_d        = 1'b1;
					state_d       = skt_pkg::S_COMPARE;
				end else begin
					idx_d   = count_last;
					state_d = skt_pkg::S_SHIFT_RD;
				end
			end
			skt_pkg::S_COMPARE: begin
				if (cmd_q == skt_pkg::CMD_LOOKUP && last_q) begin
					if (key_equal) begin
						res_status_d = skt_pkg::STATUS_OK;
						res_pos_d    = lo_q;
						res_pay_d    = rd_payload;
					end else begin
						res_status_d = skt_pkg::STATUS_MISS;
					end
					state_d = skt_pkg::S_DONE;
				end else if (key_less) begin
					lo_d    = mid + AW'(1);
					state_d = skt_pkg::S_PROBE;
				end else if (cmd_q == skt_pkg::CMD_LOOKUP && key_equal) begin
					res_status_d = skt_pkg::STATUS_OK;
					res_pos_d    = mid;
					res_pay_d    = rd_payload;
					state_d      = skt_pkg::S_DONE;
				end else begin
					hi_d    = mid;
					state_d = skt_pkg::S_PROBE;
				end
			end
			skt_pkg::S_SHIFT_RD: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr       = idx_q;
				state_d       = skt_pkg::S_SHIFT_WR;
			end
			skt_pkg::S_SHIFT_WR: begin
				// Move the entry just read one place up; walk down to the insert point.
				mem_ctl.we = 1'b1;
				if (idx_q == lo_q) begin
					state_d = skt_pkg::S_WRITE;
				end else begin
					idx_d   = idx_q - AW'(1);
					state_d = skt_pkg::S_SHIFT_RD;
				end
			end
			skt_pkg::S_WRITE: begin
				mem_ctl.we   = 1'b1;
				wr_addr      = lo_q;
				wr_key       = key_q;
				wr_payload   = pay_q;
				count_d      = count_q + CW'(1);
				res_status_d = skt_pkg::STATUS_OK;
				res_pos_d    = lo_q;
				res_pay_d    = '0;
				state_d      = skt_pkg::S_DONE;
			end
			skt_pkg::S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_valid_d  = 1'b1;
					out_status_d = res_status_q;
					out_pos_d    = res_pos_q;
					out_pay_d    = res_pay_q;
					out_total_d  = count_q;
					state_d      = skt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skt_pkg::S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q        <= cmd_d;
		key_q        <= key_d;
		pay_q        <= pay_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		idx_q        <= idx_d;
		last_q       <= last_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		res_pay_q    <= res_pay_d;
		out_status_q <= out_status_d;
		out_pos_q    <= out_pos_d;
		out_pay_q    <= out_pay_d;
		out_total_q  <= out_total_d;
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_pos     = out_pos_q;
	assign out_payload = out_pay_q;
	assign out_total   = out_total_q;

endmodule

[rtl/core/sorted_key_table_search_insert_core.sv]
// Sorted key table: up to CAPACITY entries of a 32-bit key and a 64-bit payload,
// kept in ascending key order. A lookup word binary-searches the table; an insert
// word appends or finds the lower bound, moves later entries up and writes there.
// Each word is handled alone, through the single read port of the key and payload
// memories: each search probe reads the middle entry and then compares it, an
// appending insert reads and compares only the last entry, and an insert at
// position p reads each of the n-p later entries and writes it one place up
// before it writes the new entry. A full table rejects inserts with the full
// status. The result register lets the next word be taken while a result is
// still waiting on the output. Depends on skt_pkg, skt_ctrl and skt_ram.
`timescale 1ns / 1ps

module sorted_key_table_search_insert_core #(
	parameter int CAPACITY = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [95:0]  s_axis_tdata,  // key [31:0], payload [95:32]
	input  logic [0:0]   s_axis_tuser,  // command [0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [87:0]  m_axis_tdata,  // position [9:0], found_payload [73:10],
	                                    // entry_total [84:74], zero [87:85]
	output logic [1:0]   m_axis_tuser   // status [1:0]
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (AW > skt_pkg::POS_W) ? AW : skt_pkg::POS_W;
	localparam int TW = (CW > skt_pkg::TOTAL_W) ? CW : skt_pkg::TOTAL_W;

	skt_pkg::mem_ctl_t             mem_ctl;
	logic [AW-1:0]                 rd_addr;
	logic [AW-1:0]                 wr_addr;
	logic [skt_pkg::KEY_W-1:0]     wr_key;
	logic [skt_pkg::PAYLOAD_W-1:0] wr_payload;
	logic [skt_pkg::KEY_W-1:0]     rd_key;
	logic [skt_pkg::PAYLOAD_W-1:0] rd_payload;
	logic [skt_pkg::STATUS_W-1:0]  out_status;
	logic [AW-1:0]                 out_pos;
	logic [skt_pkg::PAYLOAD_W-1:0] out_payload;
	logic [CW-1:0]                 out_total;
	logic [PW-1:0]                 pos_ext;
	logic [TW-1:0]                 total_ext;

	skt_ctrl #(
		.CAPACITY(CAPACITY),
		.AW      (AW),
		.CW      (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_cmd     (s_axis_tuser[0]),
		.in_key     (s_axis_tdata[31:0]),
		.in_payload (s_axis_tdata[95:32]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (out_status),
		.out_pos    (out_pos),
		.out_payload(out_payload),
		.out_total  (out_total),
		.mem_ctl    (mem_ctl),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.wr_key     (wr_key),
		.wr_payload (wr_payload),
		.rd_key     (rd_key),
		.rd_payload (rd_payload)
	);

	skt_ram #(
		.WIDTH(skt_pkg::KEY_W),
		.DEPTH(CAPACITY)
	) u_key_ram (
		.clk    (clk),
		.we     (mem_ctl.we),
		.wr_addr(wr_addr),
		.wr_data(wr_key),
		.rd_en  (mem_ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_key)
	);

	skt_ram #(
		.WIDTH(skt_pkg::PAYLOAD_W),
		.DEPTH(CAPACITY)
	) u_payload_ram (
		.clk    (clk),
		.we     (mem_ctl.we),
		.wr_addr(wr_addr),
		.wr_data(wr_payload),
		.rd_en  (mem_ctl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_payload)
	);

	// Position and total are reported modulo their field widths.
	assign pos_ext   = PW'(out_pos);
	assign total_ext = TW'(out_total);

	assign m_axis_tdata = {3'b000, total_ext[skt_pkg::TOTAL_W-1:0], out_payload,
		pos_ext[skt_pkg::POS_W-1:0]};
	assign m_axis_tuser = out_status;

endmodule

[rtl/core/skt_checker.sv]
// Port-level checker for the sorted key table core, bound to the top level.
// Uses skt_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "sorted_key_table_search_insert_core_assert.svh"

module skt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A result word that is held back keeps its contents.
	`SKT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// The table works on one word at a time, so it is busy right after taking one.
	`SKT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// A miss or a rejected insert reports neither a position nor a payload.
	`SKT_ASSERT_SAME(a_no_data_on_fail, clk, arst_n, m_axis_tvalid && (m_axis_tuser == skt_pkg::STATUS_MISS || m_axis_tuser == skt_pkg::STATUS_FULL), m_axis_tdata[73:0] == 74'd0)

	`SKT_ASSERT_SAME(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser == skt_pkg::STATUS_OK || m_axis_tuser == skt_pkg::STATUS_MISS || m_axis_tuser == skt_pkg::STATUS_FULL)

endmodule

bind sorted_key_table_search_insert_core skt_checker u_skt_checker (.*);
